>>> sv/sparse_accumulator_core_macros.svh
// assertion helpers shared by the sparse accumulator modules
// both expect aclk and aresetn in scope and are off while reset is held
`ifndef SPARSE_ACCUMULATOR_CORE_MACROS_SVH
`define SPARSE_ACCUMULATOR_CORE_MACROS_SVH

// same-cycle implication
`define SPACC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPACC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/spacc_pkg.sv
`default_nettype none

package spacc_pkg;

    // slot store geometry
    localparam int SLOTS  = 1024;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int VAL_W  = 32;
    localparam int THR_W  = 31;
    localparam int KIND_W = 3;

    // operation codes carried by the kind field
    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 3'd0,
        KIND_READ   = 3'd1,
        KIND_GATHER = 3'd2,
        KIND_CLEAN  = 3'd3,
        KIND_CLEAR  = 3'd4
    } kind_t;

    // datapath operation for the current cycle
    typedef enum logic [4:0] {
        DP_NOP,
        DP_ACCEPT,
        DP_SWEEP,
        DP_ADD_RD,
        DP_ADD_SUM,
        DP_ADD_WR,
        DP_RD_RD,
        DP_RD_CAP,
        DP_GA_CHK,
        DP_GA_LIST,
        DP_GA_CAP,
        DP_CL_LIST,
        DP_CL_MEM,
        DP_CL_CHK,
        DP_CR_LIST,
        DP_CR_ZERO
    } dp_op_t;

    // controller to datapath
    typedef struct packed {
        dp_op_t op;
        logic   load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic idx_at_total;
        logic pos_in_range;
        logic sweep_last;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

>>> sv/sparse_accumulator_core.sv
// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  s_kind, s_slot, s_value, s_position
// m_        out        m_valid / m_ready  m_result_value, m_result_slot,
//                                         m_live_entries, m_status
// apb       in         psel / penable     paddr, pwdata, prdata (pready tied high)
//
// one beat at a time; read: read, capture; add: read, sum, write; gather: check,
// list read, capture, or check alone when out of range; clean: list, store read,
// check per listed slot; clear: list, zero per slot; unused kinds: finish only
// add and clean read-modify-write the slot store; reset sweeps it to zero, s_ready low
// a finished result sits in the output register; the next beat waits only
// when that register is still full at the end of its work
`default_nettype none

module sparse_accumulator_core
    import spacc_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [KIND_W-1:0]        s_kind,
    input  wire logic [SLOT_W-1:0]        s_slot,
    input  wire logic signed [VAL_W-1:0]  s_value,
    input  wire logic [SLOT_W-1:0]        s_position,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [VAL_W-1:0]       m_result_value,
    output logic [SLOT_W-1:0]             m_result_slot,
    output logic [CNT_W-1:0]              m_live_entries,
    output logic                          m_status,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [2:0]               paddr,
    input  wire logic [31:0]              pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam logic REG_TINY = 1'b0;
    localparam logic REG_TOL  = 1'b1;

    logic [THR_W-1:0] tiny_reg;
    logic [THR_W-1:0] tol_reg;
    logic             cfg_wr;
    cmd_t             cmd;
    stat_t            stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tiny_reg <= THR_W'(1);
            tol_reg  <= THR_W'(1);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_TINY) begin
                tiny_reg <= pwdata[THR_W-1:0];
            end else begin
                tol_reg <= pwdata[THR_W-1:0];
            end
        end
    end

    // register read back
    always_comb begin
        unique case (paddr[2])
            REG_TINY: prdata = {1'b0, tiny_reg};
            REG_TOL:  prdata = {1'b0, tol_reg};
            default:  prdata = '0;
        endcase
    end

    spacc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .cmd     (cmd),
        .stat    (stat)
    );

    spacc_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_slot          (s_slot),
        .s_value         (s_value),
        .s_position      (s_position),
        .tiny_threshold  (tiny_reg),
        .clean_tolerance (tol_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_value  (m_result_value),
        .m_result_slot   (m_result_slot),
        .m_live_entries  (m_live_entries),
        .m_status        (m_status)
    );

endmodule

`default_nettype wire

>>> sv/spacc_dp.sv
`default_nettype none
`include "sparse_accumulator_core_macros.svh"

module spacc_dp
    import spacc_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire cmd_t                     cmd,
    output stat_t                         stat,
    input  wire logic [SLOT_W-1:0]        s_slot,
    input  wire logic signed [VAL_W-1:0]  s_value,
    input  wire logic [SLOT_W-1:0]        s_position,
    input  wire logic [THR_W-1:0]         tiny_threshold,
    input  wire logic [THR_W-1:0]         clean_tolerance,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [VAL_W-1:0]       m_result_value,
    output logic [SLOT_W-1:0]             m_result_slot,
    output logic [CNT_W-1:0]              m_live_entries,
    output logic                          m_status
);

    // slot store: {present, value}, and the live slot list
    logic [VAL_W:0]      slot_mem [SLOTS];
    logic [SLOT_W-1:0]   list_mem [SLOTS];
    logic [VAL_W:0]      slot_rd_reg;
    logic [SLOT_W-1:0]   list_rd_reg;

    // control state
    logic [CNT_W-1:0]    live_total_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    kept_reg;
    logic                m_valid_reg;

    // beat payload and working values
    logic [SLOT_W-1:0]   slot_reg;
    logic [VAL_W-1:0]    value_reg;
    logic [SLOT_W-1:0]   pos_reg;
    logic [VAL_W-1:0]    sum_reg;
    logic [VAL_W-1:0]    res_value_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic                res_status_reg;
    logic [VAL_W-1:0]    out_value_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [CNT_W-1:0]    out_live_reg;
    logic                out_status_reg;

    // memory port controls
    logic                slot_rd_en;
    logic [SLOT_W-1:0]   slot_rd_addr;
    logic                slot_wr_en;
    logic [SLOT_W-1:0]   slot_wr_addr;
    logic [VAL_W:0]      slot_wr_data;
    logic                list_rd_en;
    logic [SLOT_W-1:0]   list_rd_addr;
    logic                list_wr_en;
    logic [SLOT_W-1:0]   list_wr_addr;
    logic [SLOT_W-1:0]   list_wr_data;
    logic                add_append;

    // magnitude compare shared by add and clean, and saturating adder
    logic [VAL_W-1:0]    mag_x;
    logic [THR_W-1:0]    mag_t;
    logic [VAL_W:0]      mag_sum;
    logic                mag_ge;
    logic [VAL_W:0]      add_full;
    logic [VAL_W-1:0]    add_sat;
    logic                present;

    assign present = slot_rd_reg[VAL_W];

    // status back to the controller
    assign stat.idx_at_total = (idx_reg == live_total_reg);
    assign stat.pos_in_range = ({1'b0, pos_reg} < live_total_reg);
    assign stat.sweep_last   = (idx_reg == CNT_W'(SLOTS - 1));
    assign stat.out_free     = !m_valid_reg || m_ready;

    // operand select for the magnitude compare
    always_comb begin
        mag_x = value_reg;
        mag_t = tiny_threshold;
        if (cmd.op == DP_ADD_WR && present) begin
            mag_x = sum_reg;
        end else if (cmd.op == DP_CL_CHK) begin
            mag_x = slot_rd_reg[VAL_W-1:0];
            mag_t = clean_tolerance;
        end
    end

    // |x| >= t: for negative x this is x + t <= 0
    assign mag_sum = {mag_x[VAL_W-1], mag_x} + {2'b00, mag_t};
    assign mag_ge  = mag_x[VAL_W-1] ? (mag_sum[VAL_W] || (mag_sum == '0))
                                    : (mag_x[THR_W-1:0] >= mag_t);

    // stored value plus incoming value, clamped to the signed range
    assign add_full = {slot_rd_reg[VAL_W-1], slot_rd_reg[VAL_W-1:0]}
                    + {value_reg[VAL_W-1], value_reg};
    always_comb begin
        if (add_full[VAL_W] != add_full[VAL_W-1]) begin
            add_sat = add_full[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}}
                                      : {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
            add_sat = add_full[VAL_W-1:0];
        end
    end

    // memory port decode per operation
    always_comb begin
        slot_rd_en   = 1'b0;
        slot_rd_addr = slot_reg;
        slot_wr_en   = 1'b0;
        slot_wr_addr = list_rd_reg;
        slot_wr_data = '0;
        list_rd_en   = 1'b0;
        list_rd_addr = idx_reg[SLOT_W-1:0];
        list_wr_en   = 1'b0;
        list_wr_addr = kept_reg[SLOT_W-1:0];
        list_wr_data = list_rd_reg;
        add_append   = 1'b0;
        unique case (cmd.op)
            DP_SWEEP: begin
                slot_wr_en   = 1'b1;
                slot_wr_addr = idx_reg[SLOT_W-1:0];
            end
            DP_ADD_RD, DP_RD_RD: begin
                slot_rd_en = 1'b1;
            end
            DP_ADD_WR: begin
                slot_wr_addr = slot_reg;
                if (present) begin
                    slot_wr_en   = 1'b1;
                    slot_wr_data = {1'b1, (mag_ge ? sum_reg : {VAL_W{1'b0}})};
                end else if (mag_ge && (live_total_reg < CNT_W'(SLOTS))) begin
                    add_append   = 1'b1;
                    slot_wr_en   = 1'b1;
                    slot_wr_data = {1'b1, value_reg};
                    list_wr_en   = 1'b1;
                    list_wr_addr = live_total_reg[SLOT_W-1:0];
                    list_wr_data = slot_reg;
                end
            end
            DP_GA_CHK: begin
                list_rd_en   = stat.pos_in_range;
                list_rd_addr = pos_reg;
            end
            DP_GA_LIST, DP_CL_MEM: begin
                slot_rd_en   = 1'b1;
                slot_rd_addr = list_rd_reg;
            end
            DP_CL_LIST, DP_CR_LIST: begin
                list_rd_en = !stat.idx_at_total;
            end
            DP_CL_CHK: begin
                if (mag_ge) begin
                    list_wr_en = 1'b1;
                end else begin
                    slot_wr_en = 1'b1;
                end
            end
            DP_CR_ZERO: begin
                slot_wr_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // slot store, registered read
    always_ff @(posedge aclk) begin
        if (slot_wr_en) begin
            slot_mem[slot_wr_addr] <= slot_wr_data;
        end
        if (slot_rd_en) begin
            slot_rd_reg <= slot_mem[slot_rd_addr];
        end
    end

    // live list, registered read
    always_ff @(posedge aclk) begin
        if (list_wr_en) begin
            list_mem[list_wr_addr] <= list_wr_data;
        end
        if (list_rd_en) begin
            list_rd_reg <= list_mem[list_rd_addr];
        end
    end

    // counters and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_total_reg <= '0;
            idx_reg        <= '0;
            kept_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            case (cmd.op)
                DP_ACCEPT: begin
                    idx_reg  <= '0;
                    kept_reg <= '0;
                end
                DP_SWEEP, DP_CR_ZERO: begin
                    idx_reg <= idx_reg + 1'b1;
                end
                DP_ADD_WR: begin
                    if (add_append) begin
                        live_total_reg <= live_total_reg + 1'b1;
                    end
                end
                DP_CL_LIST: begin
                    if (stat.idx_at_total) begin
                        live_total_reg <= kept_reg;
                    end
                end
                DP_CL_CHK: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (mag_ge) begin
                        kept_reg <= kept_reg + 1'b1;
                    end
                end
                DP_CR_LIST: begin
                    if (stat.idx_at_total) begin
                        live_total_reg <= '0;
                    end
                end
                default: begin
                end
            endcase
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // beat capture, working results and output register
    always_ff @(posedge aclk) begin
        case (cmd.op)
            DP_ACCEPT: begin
                slot_reg       <= s_slot;
                value_reg      <= s_value;
                pos_reg        <= s_position;
                res_value_reg  <= '0;
                res_slot_reg   <= '0;
                res_status_reg <= 1'b0;
            end
            DP_ADD_SUM: begin
                sum_reg <= add_sat;
            end
            DP_RD_CAP: begin
                res_value_reg <= slot_rd_reg[VAL_W-1:0];
            end
            DP_GA_CHK: begin
                if (!stat.pos_in_range) begin
                    res_status_reg <= 1'b1;
                end
            end
            DP_GA_CAP: begin
                res_value_reg <= slot_rd_reg[VAL_W-1:0];
                res_slot_reg  <= list_rd_reg;
            end
            default: begin
            end
        endcase
        if (cmd.load_out) begin
            out_value_reg  <= res_value_reg;
            out_slot_reg   <= res_slot_reg;
            out_live_reg   <= live_total_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = out_value_reg;
    assign m_result_slot  = out_slot_reg;
    assign m_live_entries = out_live_reg;
    assign m_status       = out_status_reg;

    `SPACC_ASSERT_IMPL(a_total_range, 1'b1, live_total_reg <= CNT_W'(SLOTS), "live count above slot count")
    `SPACC_ASSERT_IMPL(a_kept_behind, 1'b1, kept_reg <= idx_reg, "clean write pointer passed read pointer")
    `SPACC_ASSERT_IMPL(a_load_free, cmd.load_out, !m_valid_reg || m_ready, "result loaded over a pending beat")

endmodule

`default_nettype wire

>>> sv/spacc_ctrl.sv
`default_nettype none
`include "sparse_accumulator_core_macros.svh"

module spacc_ctrl
    import spacc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [KIND_W-1:0] s_kind,
    output cmd_t                   cmd,
    input  wire stat_t             stat
);

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_SUM,
        ST_ADD_WR,
        ST_RD_RD,
        ST_RD_CAP,
        ST_GA_CHK,
        ST_GA_LIST,
        ST_GA_CAP,
        ST_CL_LIST,
        ST_CL_MEM,
        ST_CL_CHK,
        ST_CR_LIST,
        ST_CR_ZERO,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    // next state and datapath command
    always_comb begin
        state_next   = state_reg;
        cmd.op       = DP_NOP;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.op = DP_SWEEP;
                if (stat.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op = DP_ACCEPT;
                    unique case (kind_t'(s_kind))
                        KIND_ADD:    state_next = ST_ADD_RD;
                        KIND_READ:   state_next = ST_RD_RD;
                        KIND_GATHER: state_next = ST_GA_CHK;
                        KIND_CLEAN:  state_next = ST_CL_LIST;
                        KIND_CLEAR:  state_next = ST_CR_LIST;
                        default:     state_next = ST_FIN;
                    endcase
                end
            end
            ST_ADD_RD: begin
                cmd.op     = DP_ADD_RD;
                state_next = ST_ADD_SUM;
            end
            ST_ADD_SUM: begin
                cmd.op     = DP_ADD_SUM;
                state_next = ST_ADD_WR;
            end
            ST_ADD_WR: begin
                cmd.op     = DP_ADD_WR;
                state_next = ST_FIN;
            end
            ST_RD_RD: begin
                cmd.op     = DP_RD_RD;
                state_next = ST_RD_CAP;
            end
            ST_RD_CAP: begin
                cmd.op     = DP_RD_CAP;
                state_next = ST_FIN;
            end
            ST_GA_CHK: begin
                cmd.op     = DP_GA_CHK;
                state_next = stat.pos_in_range ? ST_GA_LIST : ST_FIN;
            end
            ST_GA_LIST: begin
                cmd.op     = DP_GA_LIST;
                state_next = ST_GA_CAP;
            end
            ST_GA_CAP: begin
                cmd.op     = DP_GA_CAP;
                state_next = ST_FIN;
            end
            ST_CL_LIST: begin
                cmd.op     = DP_CL_LIST;
                state_next = stat.idx_at_total ? ST_FIN : ST_CL_MEM;
            end
            ST_CL_MEM: begin
                cmd.op     = DP_CL_MEM;
                state_next = ST_CL_CHK;
            end
            ST_CL_CHK: begin
                cmd.op     = DP_CL_CHK;
                state_next = ST_CL_LIST;
            end
            ST_CR_LIST: begin
                cmd.op     = DP_CR_LIST;
                state_next = stat.idx_at_total ? ST_FIN : ST_CR_ZERO;
            end
            ST_CR_ZERO: begin
                cmd.op     = DP_CR_ZERO;
                state_next = ST_CR_LIST;
            end
            ST_FIN: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register, sweep runs first after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    `SPACC_ASSERT_NEXT(a_no_resweep, state_reg == ST_IDLE, state_reg != ST_INIT, "sweep restarted after idle")
    `SPACC_ASSERT_NEXT(a_accept_leaves, s_valid && state_reg == ST_IDLE, state_reg != ST_IDLE, "accepted beat not started")

endmodule

`default_nettype wire
